### hdl/wmps_pkg.sv
// ----------------------------------------------------------------------------
// wmps_pkg
// shared types and constants for the masked word pattern scan
// ----------------------------------------------------------------------------
package wmps_pkg;

	localparam int WORD_W  = 32;
	localparam int ADDR_W  = 48;
	localparam int INDEX_W = 6;
	localparam int LEN_W   = 7;
	localparam int KIND_W  = 2;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [KIND_W-1:0] REQ_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] REQ_BEGIN = 2'd1;
	localparam logic [KIND_W-1:0] REQ_DATA  = 2'd2;
	localparam logic [KIND_W-1:0] REQ_END   = 2'd3;

	localparam logic [WORD_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [KIND_W-1:0]  req_type;
		logic [INDEX_W-1:0] entry_index;
		logic [WORD_W-1:0]  entry_value;
		logic [WORD_W-1:0]  entry_mask;
		logic [WORD_W-1:0]  data_word;
		logic [ADDR_W-1:0]  word_address;
		logic               segment_first;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] match_address;
		logic [WORD_W-1:0] match_total;
		logic              unique_found;
	} rsp_t;

	// classified word held in the queue between front and back
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] index;
		logic [WORD_W-1:0]  word;
		logic [WORD_W-1:0]  mask;
		logic [ADDR_W-1:0]  address;
		logic               first;
	} cmd_t;

endpackage

### hdl/wmps_front.sv
// ----------------------------------------------------------------------------
// wmps_front
// accepts request words, classifies them and pushes them into the queue
// ----------------------------------------------------------------------------
module wmps_front #(
	parameter int MAX_PATTERN = 64
) (
	input  logic           req_valid,
	output logic           req_stall,
	input  wmps_pkg::req_t req,
	input  logic           full,
	output logic           push,
	output wmps_pkg::cmd_t push_cmd
);
	import wmps_pkg::*;

	logic accept;
	logic load_dropped;

	assign req_stall    = full;
	assign accept       = req_valid && !full;
	// loads beyond the pattern store are discarded here
	assign load_dropped = (req.req_type == REQ_LOAD) && (int'(req.entry_index) >= MAX_PATTERN);
	assign push         = accept && !load_dropped;

	always_comb begin
		push_cmd         = '0;
		push_cmd.kind    = req.req_type;
		push_cmd.index   = req.entry_index;
		push_cmd.mask    = req.entry_mask;
		push_cmd.address = req.word_address;
		push_cmd.first   = req.segment_first;
		unique case (req.req_type)
			REQ_LOAD: begin
				push_cmd.word = req.entry_value;
			end
			REQ_DATA: begin
				push_cmd.word = req.data_word;
			end
			default: begin
				push_cmd.word = '0;
			end
		endcase
	end

endmodule

### hdl/wmps_queue.sv
// ----------------------------------------------------------------------------
// wmps_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module wmps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wmps_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           head_valid,
	output wmps_pkg::cmd_t head,
	input  logic           pop
);
	import wmps_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

### hdl/wmps_back.sv
// ----------------------------------------------------------------------------
// wmps_back
// pattern store, partial-match chain, match counting and result register
// ----------------------------------------------------------------------------
module wmps_back #(
	parameter int MAX_PATTERN = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  wmps_pkg::cmd_t               head,
	output logic                         pop,
	input  logic [wmps_pkg::LEN_W-1:0]   pattern_length,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output wmps_pkg::rsp_t               rsp
);
	import wmps_pkg::*;

	logic [WORD_W-1:0]      pat_value_q [MAX_PATTERN];
	logic [WORD_W-1:0]      pat_mask_q  [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] chain_q;
	logic [MAX_PATTERN-1:0] chain_base;
	logic [MAX_PATTERN-1:0] chain_next;
	logic [MAX_PATTERN-1:0] hit;
	logic [MAX_PATTERN-1:0] len_sel;

	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [WORD_W-1:0] count_q;
	logic [ADDR_W-1:0] last_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              out_free;
	logic              go_s1;
	logic              matched;
	logic              uniq;
	logic [LEN_W-1:0]  len_m1;
	logic [ADDR_W-1:0] start_addr;

	// pop stage: masked compares against every entry
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			hit[i] = ((head.word ^ pat_value_q[i]) & pat_mask_q[i]) == '0;
		end
		chain_base    = head.first ? '0 : chain_q;
		chain_next    = '0;
		chain_next[0] = hit[0];
		for (int i = 1; i < MAX_PATTERN; i++) begin
			chain_next[i] = chain_base[i-1] && hit[i];
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign go_s1    = valid_s1 && ((kind_s1 != REQ_END) || out_free);
	assign pop      = head_valid && (!valid_s1 || go_s1);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (pop && (head.kind == REQ_LOAD) && (int'(head.index) == i)) begin
				pat_value_q[i] <= head.word;
				pat_mask_q[i]  <= head.mask;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (pop && (head.kind == REQ_BEGIN)) begin
			chain_q <= '0;
		end else if (pop && (head.kind == REQ_DATA)) begin
			chain_q <= chain_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= head.kind;
			addr_s1 <= head.address;
		end
	end

	// stage one: chain_q holds the chain left by the word in this stage
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			len_sel[i] = chain_q[i] && (int'(pattern_length) == i + 1);
		end
	end

	assign matched    = |len_sel;
	assign len_m1     = pattern_length - 1'b1;
	assign start_addr = addr_s1 - {{(ADDR_W-LEN_W-2){1'b0}}, len_m1, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
		end else if (go_s1 && (kind_s1 == REQ_BEGIN)) begin
			count_q <= '0;
			last_q  <= '0;
		end else if (go_s1 && (kind_s1 == REQ_DATA) && matched) begin
			if (count_q != COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			last_q <= start_addr;
		end
	end

	assign uniq = (count_q == WORD_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go_s1 && (kind_s1 == REQ_END)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && (kind_s1 == REQ_END)) begin
			rsp_q.match_address <= uniq ? last_q : '0;
			rsp_q.match_total   <= count_q;
			rsp_q.unique_found  <= uniq;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hdl/masked_word_pattern_scan.sv
// an end word passes through the queue and stage one before its result word is registered
// throughput: one word per cycle, every word type; a stalled result holds the back end
// the queue between front and back is four words deep and absorbs short stalls
// reset: asynchronous, active low; clears counts, match chain and queue, length to 1
// the pattern store is not cleared by reset
// ----------------------------------------------------------------------------
// masked_word_pattern_scan
// masked signature scan over a stream of 32-bit words
// ----------------------------------------------------------------------------
module masked_word_pattern_scan #(
	parameter int MAX_PATTERN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  wmps_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output wmps_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [wmps_pkg::LEN_W-1:0] cfg_data
);
	import wmps_pkg::*;

	logic             full;
	logic             push;
	cmd_t             push_cmd;
	logic             head_valid;
	cmd_t             head;
	logic             pop;
	logic [LEN_W-1:0] pattern_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LEN_W'(1);
		end else if (cfg_we) begin
			pattern_length_q <= cfg_data;
		end
	end

	wmps_front #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_front (
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	wmps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	wmps_back #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.pattern_length(pattern_length_q),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp)
	);

endmodule
